/* rtl/multibit_trie_ip_lookup_macros.svh */
// assertion macros for the multibit trie lookup block
// used by modules that carry concurrent checks; expects clk and rst in scope
`ifndef MULTIBIT_TRIE_IP_LOOKUP_MACROS_SVH
`define MULTIBIT_TRIE_IP_LOOKUP_MACROS_SVH
`ifndef ASSERT_OFF
`define MTRIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MTRIE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MTRIE_ASSERT(lbl, prop, msg)
`define MTRIE_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/mtrie_pkg.sv */
// shared types and constants for the multibit trie lookup block
// no dependencies
`default_nettype none

package mtrie_pkg;

  localparam int TABLE_WORDS_DEF = 65536;
  localparam int KEY_W = 64;
  localparam int WORD_W = 32;
  localparam int LEAF_BIT = WORD_W - 1;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_CORRUPT = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic REG_STRIDE = 1'b0;
  localparam logic REG_NODES = 1'b1;

  localparam logic MODE_WRITE = 1'b0;

  typedef struct packed {
    logic [3:0] stride_bits;
    logic [16:0] node_count;
  } cfg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ_HI,
    S_READ_CHILD,
    S_READ_LO
  } walk_state_t;

endpackage

`default_nettype wire

/* rtl/mtrie_regs.sv */
// apb configuration registers: stride and node count
// depends on mtrie_pkg
`default_nettype none

module mtrie_regs
  import mtrie_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;
  logic reg_sel;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stride_bits <= 4'd8;
      cfg.node_count <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STRIDE: cfg.stride_bits <= pwdata[3:0];
        REG_NODES: cfg.node_count <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STRIDE: prdata = {28'd0, cfg.stride_bits};
      REG_NODES: prdata = {15'd0, cfg.node_count};
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mtrie_mem.sv */
// trie word memory, single port, registered read data
// depends on nothing
`default_nettype none

module mtrie_mem #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* rtl/mtrie_walk.sv */
// request control and trie walk sequencer over the word memory
// depends on mtrie_pkg and multibit_trie_ip_lookup_macros.svh
`default_nettype none
`include "multibit_trie_ip_lookup_macros.svh"

module mtrie_walk
  import mtrie_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF,
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          start,
  input  wire logic          mode,
  input  wire logic [15:0]   word_index,
  input  wire logic [31:0]   word_data,
  input  wire logic          is_ipv6,
  input  wire logic [63:0]   address,
  output logic               busy,
  output logic               done,
  output logic [1:0]         status,
  output logic [62:0]        value,
  output logic               mem_we,
  output logic [AW-1:0]      mem_addr,
  output logic [31:0]        mem_wdata,
  input  wire logic [31:0]   mem_rdata
);

  walk_state_t state, state_next;
  logic [KEY_W-1:0] key, key_next;
  logic [6:0] pos, pos_next;
  logic [AW-1:0] node, node_next;
  logic [30:0] hi_word, hi_word_next;
  logic done_next;
  logic [1:0] status_next;
  logic [62:0] value_next;

  logic [3:0] s;
  logic stride_ok;
  logic oversize;
  logic accept;
  logic wr_accept;
  logic in_range;
  logic [31:0] widx;
  logic [KEY_W-1:0] key_in;

  function automatic logic [AW-1:0] shl(input logic [AW-1:0] n, input logic [3:0] sb);
    logic [AW-1:0] r;
    case (sb)
      4'd1: r = n << 1;
      4'd2: r = n << 2;
      4'd4: r = n << 4;
      default: r = n << 8;
    endcase
    return r;
  endfunction

  function automatic logic [AW-1:0] slot_of(input logic [KEY_W-1:0] k, input logic [3:0] sb);
    logic [AW-1:0] r;
    case (sb)
      4'd1: r = AW'(k[63]);
      4'd2: r = AW'(k[63:62]);
      4'd4: r = AW'(k[63:60]);
      default: r = AW'(k[63:56]);
    endcase
    return r;
  endfunction

  assign s = cfg.stride_bits;
  assign stride_ok = (s == 4'd1) || (s == 4'd2) || (s == 4'd4) || (s == 4'd8);
  assign oversize = (32'(TABLE_WORDS) >> s) < 32'(cfg.node_count);
  assign busy = (state != S_IDLE);
  assign accept = start && !busy;
  assign wr_accept = accept && (mode == MODE_WRITE);
  assign widx = 32'(word_index);
  assign in_range = widx < 32'(TABLE_WORDS);
  assign key_in = is_ipv6 ? address : {address[31:0], 32'd0};
  assign mem_wdata = word_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    pos <= pos_next;
    node <= node_next;
    hi_word <= hi_word_next;
    status <= status_next;
    value <= value_next;
  end

  always_comb begin
    state_next = state;
    key_next = key;
    pos_next = pos;
    node_next = node;
    hi_word_next = hi_word;
    done_next = 1'b0;
    status_next = status;
    value_next = value;
    mem_we = 1'b0;
    mem_addr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          done_next = 1'b1;
          value_next = '0;
          if (mode == MODE_WRITE) begin
            mem_we = in_range;
            mem_addr = widx[AW-1:0];
            status_next = ST_WRITTEN;
          end else if (cfg.node_count == '0) begin
            status_next = ST_NOT_FOUND;
          end else if (!stride_ok || oversize) begin
            status_next = ST_CORRUPT;
          end else begin
            done_next = 1'b0;
            mem_addr = AW'(1);
            key_next = key_in;
            pos_next = 7'd64;
            node_next = '0;
            state_next = S_READ_HI;
          end
        end
      end
      S_READ_HI: begin
        if (mem_rdata[LEAF_BIT]) begin
          hi_word_next = mem_rdata[30:0];
          mem_addr = shl(node, s);
          state_next = S_READ_LO;
        end else if (pos == 7'd0) begin
          done_next = 1'b1;
          status_next = ST_NOT_FOUND;
          value_next = '0;
          state_next = S_IDLE;
        end else begin
          mem_addr = shl(node, s) | slot_of(key, s);
          key_next = key << s;
          pos_next = 7'(pos - {3'd0, s});
          state_next = S_READ_CHILD;
        end
      end
      S_READ_CHILD: begin
        if (mem_rdata >= 32'(cfg.node_count)) begin
          done_next = 1'b1;
          status_next = ST_CORRUPT;
          value_next = '0;
          state_next = S_IDLE;
        end else if (mem_rdata == '0) begin
          done_next = 1'b1;
          status_next = ST_NOT_FOUND;
          value_next = '0;
          state_next = S_IDLE;
        end else begin
          node_next = mem_rdata[AW-1:0];
          mem_addr = shl(mem_rdata[AW-1:0], s) | AW'(1);
          state_next = S_READ_HI;
        end
      end
      S_READ_LO: begin
        done_next = 1'b1;
        status_next = ST_FOUND;
        value_next = {hi_word, mem_rdata};
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `MTRIE_ASSERT(a_value_zero, (done && status != ST_FOUND) |-> (value == '0), "value without hit")
  `MTRIE_NEVER(a_write_busy, mem_we && busy, "table write during a walk")
  `MTRIE_ASSERT(a_write_ack, (done && status == ST_WRITTEN) |-> $past(wr_accept), "stray write status")
  `MTRIE_ASSERT(a_stride_walk, busy |-> stride_ok, "walk with invalid stride")

endmodule

`default_nettype wire

/* rtl/multibit_trie_ip_lookup.sv */
// multibit trie longest prefix match lookup; a write request strobes its result the next cycle
// a lookup walks the trie level by level and strobes on a leaf hit, a miss or a bad child; an empty
// trie or a bad stride or size answers the next cycle; a leaf hit reads its low word last
// one request at a time, two dependent word reads per level; busy drops in the strobe cycle
// synchronous active high reset: stride 8, node count 0, idle; table undefined until written
// depends on mtrie_pkg, mtrie_regs, mtrie_mem, mtrie_walk
`default_nettype none

module multibit_trie_ip_lookup
  import mtrie_pkg::*;
#(
  parameter int TABLE_WORDS = TABLE_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        mode,
  input  wire logic [15:0] word_index,
  input  wire logic [31:0] word_data,
  input  wire logic        is_ipv6,
  input  wire logic [63:0] address,
  output logic             done,
  output logic [1:0]       status,
  output logic [62:0]      value,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(TABLE_WORDS);

  cfg_t cfg;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata;
  logic [31:0] mem_rdata;

  mtrie_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtrie_mem #(
    .DEPTH (TABLE_WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  mtrie_walk #(
    .TABLE_WORDS (TABLE_WORDS),
    .AW          (AW)
  ) u_walk (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .mode       (mode),
    .word_index (word_index),
    .word_data  (word_data),
    .is_ipv6    (is_ipv6),
    .address    (address),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .value      (value),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata),
    .mem_rdata  (mem_rdata)
  );

endmodule

`default_nettype wire
